// ===== rtl/core/gre_pkg.sv =====
// ----------------------------------------------------------------------------
// gre_pkg
// Shared types and constants for the gamepad report to key event block.
// ----------------------------------------------------------------------------
package gre_pkg;

	localparam int unsigned KeyW   = 24;
	localparam int unsigned NumRegs = 8;
	localparam int unsigned IdxW   = 3;
	localparam int unsigned NumEv  = 12;

	// register indexes
	localparam logic [IdxW-1:0] REG_UP        = 3'd0;
	localparam logic [IdxW-1:0] REG_DOWN      = 3'd1;
	localparam logic [IdxW-1:0] REG_LEFT      = 3'd2;
	localparam logic [IdxW-1:0] REG_RIGHT     = 3'd3;
	localparam logic [IdxW-1:0] REG_CONFIRM   = 3'd4;
	localparam logic [IdxW-1:0] REG_CANCEL    = 3'd5;
	localparam logic [IdxW-1:0] REG_PAGE_UP   = 3'd6;
	localparam logic [IdxW-1:0] REG_PAGE_DOWN = 3'd7;

	localparam logic [KeyW-1:0] REG_RESET [NumRegs] = '{
		24'h800048, 24'h800050, 24'h80004B, 24'h80004D,
		24'd13, 24'd27, 24'h800049, 24'h800051
	};

	// fixed key codes
	localparam logic [KeyW-1:0] CODE_EDIT = 24'h000065;
	localparam logic [KeyW-1:0] CODE_CMD  = 24'h000063;
	localparam logic [KeyW-1:0] CODE_ESC  = 24'd27;

	// axis zones and reset value of the kept report
	localparam logic [7:0] ZONE_LOW   = 8'h3F;
	localparam logic [7:0] ZONE_HIGH  = 8'hBF;
	localparam logic [7:0] PREV_RESET = 8'h7F;

	// event bits, in emission order
	localparam int unsigned EV_UP     = 0;
	localparam int unsigned EV_DOWN   = 1;
	localparam int unsigned EV_LEFT   = 2;
	localparam int unsigned EV_RIGHT  = 3;
	localparam int unsigned EV_A      = 4;
	localparam int unsigned EV_B      = 5;
	localparam int unsigned EV_START  = 6;
	localparam int unsigned EV_SELECT = 7;
	localparam int unsigned EV_Y      = 8;
	localparam int unsigned EV_X      = 9;
	localparam int unsigned EV_L      = 10;
	localparam int unsigned EV_R      = 11;

	// button byte bit positions (BACK is the select button, MENU the start button)
	localparam int unsigned BTN_X    = 0;
	localparam int unsigned BTN_A    = 1;
	localparam int unsigned BTN_B    = 2;
	localparam int unsigned BTN_Y    = 3;
	localparam int unsigned BTN_L    = 4;
	localparam int unsigned BTN_R    = 5;
	localparam int unsigned BTN_BACK = 6;
	localparam int unsigned BTN_MENU = 7;

	typedef logic [NumEv-1:0] ev_mask_t;

	typedef struct packed {
		logic [7:0] x_position;
		logic [7:0] y_position;
		logic [7:0] button_bits;
		logic       report_ok;
	} report_t;

	typedef struct packed {
		logic [KeyW-1:0] key_code;
		logic            last_key;
	} key_event_t;

	// queue side handshake between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== rtl/core/gre_queue.sv =====
// ----------------------------------------------------------------------------
// gre_queue
// Small register FIFO of event masks between front and back.
// ----------------------------------------------------------------------------
module gre_queue #(
	parameter int unsigned Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  gre_pkg::ev_mask_t wr_data,
	input  logic             rd,
	output gre_pkg::ev_mask_t rd_data,
	output gre_pkg::q_status_t status
);
	import gre_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	ev_mask_t          mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign status.full  = (count_q == CntW'(Depth));
	assign status.empty = (count_q == '0);
	assign do_wr        = wr && !status.full;
	assign do_rd        = rd && !status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/gre_front.sv =====
// ----------------------------------------------------------------------------
// gre_front
// Accepts reports, compares them with the kept report, and builds the
// mask of key events for the queue.
// ----------------------------------------------------------------------------
module gre_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gre_pkg::report_t  report,
	input  logic              q_full,
	output logic              full,
	output logic              q_wr,
	output gre_pkg::ev_mask_t q_data
);
	import gre_pkg::*;

	logic [7:0] prev_x_q;
	logic [7:0] prev_y_q;
	logic [7:0] prev_btn_q;
	logic [7:0] pressed;
	logic       take;
	ev_mask_t   mask;

	assign full    = q_full;
	assign take    = push && !q_full && report.report_ok;
	assign pressed = report.button_bits & ~prev_btn_q;

	always_comb begin
		mask = '0;
		mask[EV_UP]    = (report.y_position < ZONE_LOW) && (prev_y_q >= ZONE_LOW);
		mask[EV_DOWN]  = (report.y_position > ZONE_HIGH) && (prev_y_q <= ZONE_HIGH);
		mask[EV_LEFT]  = (report.x_position < ZONE_LOW) && (prev_x_q >= ZONE_LOW);
		mask[EV_RIGHT] = (report.x_position > ZONE_HIGH) && (prev_x_q <= ZONE_HIGH);
		mask[EV_A]      = pressed[BTN_A];
		mask[EV_B]      = pressed[BTN_B];
		mask[EV_START]  = pressed[BTN_MENU];
		mask[EV_SELECT] = pressed[BTN_BACK];
		mask[EV_Y]      = pressed[BTN_Y];
		mask[EV_X]      = pressed[BTN_X];
		mask[EV_L]      = pressed[BTN_L];
		mask[EV_R]      = pressed[BTN_R];
	end

	// reports with no edges never reach the queue
	assign q_wr   = take && (mask != '0);
	assign q_data = mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q   <= PREV_RESET;
			prev_y_q   <= PREV_RESET;
			prev_btn_q <= PREV_RESET;
		end else if (take) begin
			prev_x_q   <= report.x_position;
			prev_y_q   <= report.y_position;
			prev_btn_q <= report.button_bits;
		end
	end

endmodule

// ===== rtl/core/gre_back.sv =====
// ----------------------------------------------------------------------------
// gre_back
// Walks each event mask lowest bit first into the output register, one key
// a cycle while that register is free or popped. Holds the key code registers.
// ----------------------------------------------------------------------------
module gre_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [gre_pkg::IdxW-1:0] cfg_index,
	input  logic [gre_pkg::KeyW-1:0] cfg_data,
	input  logic                  q_empty,
	input  gre_pkg::ev_mask_t     q_data,
	output logic                  q_rd,
	input  logic                  pop,
	output logic                  empty,
	output gre_pkg::key_event_t   key_event
);
	import gre_pkg::*;

	logic [KeyW-1:0] reg_q [NumRegs];
	logic [KeyW-1:0] code [NumEv];
	ev_mask_t        cur_q;
	ev_mask_t        first;
	ev_mask_t        rest;
	ev_mask_t        cur_next;
	logic            out_valid_q;
	key_event_t      out_q;
	logic            out_free;
	logic            advance;
	logic [KeyW-1:0] sel_code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumRegs; i++) begin
				reg_q[i] <= REG_RESET[i];
			end
		end else if (cfg_write) begin
			reg_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		code[EV_UP]     = reg_q[REG_UP];
		code[EV_DOWN]   = reg_q[REG_DOWN];
		code[EV_LEFT]   = reg_q[REG_LEFT];
		code[EV_RIGHT]  = reg_q[REG_RIGHT];
		code[EV_A]      = reg_q[REG_CONFIRM];
		code[EV_B]      = reg_q[REG_CANCEL];
		code[EV_START]  = reg_q[REG_CONFIRM];
		code[EV_SELECT] = CODE_EDIT;
		code[EV_Y]      = CODE_CMD;
		code[EV_X]      = CODE_ESC;
		code[EV_L]      = reg_q[REG_PAGE_UP];
		code[EV_R]      = reg_q[REG_PAGE_DOWN];
	end

	assign first = cur_q & (~cur_q + 1'b1);
	assign rest  = cur_q & ~first;

	always_comb begin
		sel_code = '0;
		for (int i = 0; i < NumEv; i++) begin
			sel_code = sel_code | (code[i] & {KeyW{first[i]}});
		end
	end

	assign out_free = !out_valid_q || pop;
	assign advance  = (cur_q != '0) && out_free;
	assign cur_next = advance ? rest : cur_q;
	assign q_rd     = (cur_next == '0) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cur_q <= q_rd ? q_data : cur_next;
			if (out_free) begin
				out_valid_q <= advance;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.key_code <= sel_code;
			out_q.last_key <= (rest == '0);
		end
	end

	assign empty     = !out_valid_q;
	assign key_event = out_q;

endmodule

// ===== rtl/core/gamepad_report_to_key_events.sv =====
// ----------------------------------------------------------------------------
// gamepad_report_to_key_events
// Turns gamepad reports into a stream of key code transactions.
// ----------------------------------------------------------------------------
//
//  channel    | handshake          | payload
//  -----------+--------------------+-------------------------------------------
//  report in  | push / full        | report (x_position, y_position,
//             |                    |         button_bits, report_ok)
//  key out    | pop / empty        | key_event (key_code, last_key)
//  config     | cfg_write          | cfg_index (0..7), cfg_data (24-bit code)
//
// A report is taken whenever the event queue has room; reports
// that cause no key, or that carry report_ok low, leave nothing behind.
// The back end emits one key per cycle while pop keeps the output free; a
// report yields at most ten keys. The first key passes through the queue,
// the current mask register and the output register. The key stream is
// bounded by the one-key-per-cycle walk over each report's event mask.
// Reset (arst_n low) clears the queue and output, restores the kept report to
// 0x7F per byte and the key code registers to their defaults.
// A stalled pop holds the output; the queue then fills and raises full.
//
module gamepad_report_to_key_events #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// report side
	input  logic                        push,
	output logic                        full,
	input  gre_pkg::report_t            report,
	// key event side
	output logic                        empty,
	input  logic                        pop,
	output gre_pkg::key_event_t         key_event,
	// key code registers
	input  logic                        cfg_write,
	input  logic [gre_pkg::IdxW-1:0]    cfg_index,
	input  logic [gre_pkg::KeyW-1:0]    cfg_data
);
	import gre_pkg::*;

	ev_mask_t  q_wr_data;
	ev_mask_t  q_rd_data;
	logic      q_wr;
	logic      q_rd;
	q_status_t q_status;

	// front: edge detection against the kept report
	gre_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.report (report),
		.q_full (q_status.full),
		.full   (full),
		.q_wr   (q_wr),
		.q_data (q_wr_data)
	);

	// event masks waiting for the back end
	gre_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.status  (q_status)
	);

	// back: one key per cycle, while the output is free, into the output register
	gre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_empty   (q_status.empty),
		.q_data    (q_rd_data),
		.q_rd      (q_rd),
		.pop       (pop),
		.empty     (empty),
		.key_event (key_event)
	);

endmodule
